### rtl/vsf_pkg.sv
// Package for the vertex scale with falloff block.
// Holds register indexes, weight selection codes and fixed field widths.
// No dependencies.
package vsf_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned LANE_W     = 16;
  localparam int unsigned FD_W       = 15;
  localparam int unsigned QUO_W      = 16;
  localparam int unsigned WGT_W      = 17;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_XYZ      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_POINT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FALLOFF_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FALLOFF_POINT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FALLOFF_DIR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_DISTANCE  = 3'd5;

  // Reset value of the scale register: 1.0 in Q4.12 on every axis
  localparam logic [CFG_DATA_W-1:0] SCALE_RESET = 48'h1000_1000_1000;

  // Full weight in Q1.16
  localparam logic [WGT_W-1:0] WGT_ONE = 17'h10000;

  // How the final weight is chosen
  typedef enum logic [1:0] {
    WSEL_ZERO,
    WSEL_ONE,
    WSEL_QUO
  } wsel_t;

endpackage

### rtl/vsf_if.sv
// Channel interfaces for the vertex scale with falloff block.
// Uses vsf_pkg for the configuration field widths.
interface vsf_pos_in_if #(parameter int unsigned COORD_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface vsf_pos_out_if #(parameter int unsigned COORD_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;
  logic                          was_changed;
  modport source (output valid, out_x, out_y, out_z, was_changed, input ready);
  modport sink   (input valid, out_x, out_y, out_z, was_changed, output ready);
endinterface

interface vsf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [vsf_pkg::CFG_IDX_W-1:0]    index;
  logic [vsf_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/vertex_scale_with_falloff.sv
// Top level of the vertex scale with falloff block: register file and
// the full datapath pipeline. Depends on vsf_pkg and the vsf_if interfaces.
//
// Usage:
//   cfg      : register writes (index, data); always ready. Write only
//              while no vertex is in flight.
//   pos_in   : one vertex (pos_x, pos_y, pos_z) per transfer.
//   pos_out  : scaled vertex (out_x, out_y, out_z, was_changed).
// Throughput: one vertex per clock while pos_out does not stall. The
// result passes 23 register stages: input register, subtract,
// multiply, sum and round, weight classify, 16 long-division stages
// (one quotient bit each), weight multiply and output register.
// When pos_out stalls, the whole pipeline holds and pos_in.ready drops
// while the output register is full and not taken; nothing is lost or
// repeated.
// Reset (rst, synchronous) clears all valid bits and loads the register
// defaults: unit scale, zero points and direction, falloff off.
module vertex_scale_with_falloff #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  vsf_cfg_if.sink      cfg,
  vsf_pos_in_if.sink   pos_in,
  vsf_pos_out_if.source pos_out
);

  localparam int unsigned LW  = vsf_pkg::LANE_W;
  localparam int unsigned XW  = ((COORD_WIDTH > LW) ? COORD_WIDTH : LW) + 1;
  localparam int unsigned PW  = XW + LW;       // lane products
  localparam int unsigned DW  = XW + 18;       // dot product
  localparam int unsigned NW  = DW + 2;        // dividend (dot * 4)
  localparam int unsigned SW  = PW + 1;        // rounded scale sum
  localparam int unsigned FW  = XW + 6;        // ds - d
  localparam int unsigned MW  = FW + 18;       // weighted delta product
  localparam int unsigned TW  = MW + 1;
  localparam int unsigned RW  = TW - 16 + 1;   // p + delta
  localparam int unsigned QW  = vsf_pkg::QUO_W;
  localparam int unsigned NST = QW;            // division stages

  // Configuration registers
  logic [vsf_pkg::CFG_DATA_W-1:0] scale_xyz;
  logic [vsf_pkg::CFG_DATA_W-1:0] ref_point;
  logic                           falloff_enable;
  logic [vsf_pkg::CFG_DATA_W-1:0] falloff_point;
  logic [vsf_pkg::CFG_DATA_W-1:0] falloff_dir;
  logic [vsf_pkg::FD_W-1:0]       full_distance;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_xyz      <= vsf_pkg::SCALE_RESET;
      ref_point      <= '0;
      falloff_enable <= 1'b0;
      falloff_point  <= '0;
      falloff_dir    <= '0;
      full_distance  <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        vsf_pkg::REG_SCALE_XYZ:      scale_xyz      <= cfg.data;
        vsf_pkg::REG_REF_POINT:      ref_point      <= cfg.data;
        vsf_pkg::REG_FALLOFF_ENABLE: falloff_enable <= cfg.data[0];
        vsf_pkg::REG_FALLOFF_POINT:  falloff_point  <= cfg.data;
        vsf_pkg::REG_FALLOFF_DIR:    falloff_dir    <= cfg.data;
        vsf_pkg::REG_FULL_DISTANCE:  full_distance  <= cfg.data[vsf_pkg::FD_W-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves unless the output register is held
  logic adv;
  logic out_valid;
  assign adv          = !out_valid || pos_out.ready;
  assign pos_in.ready = adv;

  // Stage 0: input register
  logic                          s0_valid;
  logic signed [COORD_WIDTH-1:0] s0_p [0:2];
  // Stage 1: offsets from falloff point and reference point
  logic                          s1_valid;
  logic signed [COORD_WIDTH-1:0] s1_p [0:2];
  logic signed [XW-1:0]          s1_a [0:2];
  logic signed [XW-1:0]          s1_d [0:2];
  // Stage 2: lane products
  logic                          s2_valid;
  logic signed [COORD_WIDTH-1:0] s2_p [0:2];
  logic signed [XW-1:0]          s2_d [0:2];
  logic signed [PW-1:0]          s2_dp [0:2];
  logic signed [PW-1:0]          s2_sp [0:2];
  // Stage 3: dot product and scaled difference
  logic                          s3_valid;
  logic signed [COORD_WIDTH-1:0] s3_p [0:2];
  logic signed [FW-1:0]          s3_diff [0:2];
  logic signed [DW-1:0]          s3_dot;
  // Division pipeline, entry 0 is the classify stage
  logic                          dv_valid [0:NST];
  logic signed [COORD_WIDTH-1:0] dv_p    [0:NST][0:2];
  logic signed [FW-1:0]          dv_diff [0:NST][0:2];
  logic [NW-1:0]                 dv_rem  [0:NST];
  logic [QW-1:0]                 dv_quo  [0:NST];
  vsf_pkg::wsel_t                dv_wsel [0:NST];
  // Weight multiply stage
  logic                          m_valid;
  logic signed [COORD_WIDTH-1:0] m_p [0:2];
  logic signed [MW-1:0]          m_prod [0:2];
  logic                          m_changed;
  // Output register
  logic signed [COORD_WIDTH-1:0] o_c [0:2];
  logic                          o_changed;

  logic signed [SW-1:0] ds_sum [0:2];
  logic [NW-1:0]        num;
  logic [NW-1:0]        full_lim;
  logic                 dot_pos;
  vsf_pkg::wsel_t       wsel_c;
  logic [NW-1:0]        rem_next [0:NST-1];
  logic [QW-1:0]        quo_next [0:NST-1];
  logic [NW-1:0]        div_cmp  [0:NST-1];
  logic [vsf_pkg::WGT_W-1:0] wgt;
  logic signed [TW-1:0] rnd [0:2];
  logic signed [RW-1:0] res [0:2];
  logic signed [COORD_WIDTH-1:0] sat [0:2];

  // Rounding of d * s to Q8.8
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ds_sum[k] = SW'(s2_sp[k]) + SW'(2048);
    end
  end

  // Weight classification
  always_comb begin
    dot_pos  = !s3_dot[DW-1] && (s3_dot != '0);
    num      = NW'($unsigned(s3_dot)) << 2;
    full_lim = NW'(full_distance) << 16;
    if (!falloff_enable) begin
      wsel_c = vsf_pkg::WSEL_ONE;
    end else if (!dot_pos) begin
      wsel_c = vsf_pkg::WSEL_ZERO;
    end else if (full_distance == '0) begin
      wsel_c = vsf_pkg::WSEL_ONE;
    end else if (num >= full_lim) begin
      wsel_c = vsf_pkg::WSEL_ONE;
    end else begin
      wsel_c = vsf_pkg::WSEL_QUO;
    end
  end

  // One restoring division step per stage, most significant bit first
  always_comb begin
    for (int j = 0; j < NST; j++) begin
      div_cmp[j]  = NW'(full_distance) << (QW - 1 - j);
      rem_next[j] = dv_rem[j];
      quo_next[j] = dv_quo[j];
      if (dv_rem[j] >= div_cmp[j]) begin
        rem_next[j]            = dv_rem[j] - div_cmp[j];
        quo_next[j][QW-1-j]    = 1'b1;
      end
    end
  end

  // Final weight
  always_comb begin
    case (dv_wsel[NST])
      vsf_pkg::WSEL_ONE:  wgt = vsf_pkg::WGT_ONE;
      vsf_pkg::WSEL_QUO:  wgt = {1'b0, dv_quo[NST]};
      default:            wgt = '0;
    endcase
  end

  // Rounding of the weighted delta, add and saturate
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rnd[k] = TW'(m_prod[k]) + TW'(32768);
      res[k] = RW'(m_p[k]) + RW'($signed(rnd[k][TW-1:16]));
      if (res[k][RW-1:COORD_WIDTH-1] == '0 || res[k][RW-1:COORD_WIDTH-1] == '1) begin
        sat[k] = res[k][COORD_WIDTH-1:0];
      end else if (res[k][RW-1]) begin
        sat[k] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
        sat[k] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      for (int j = 0; j <= NST; j++) begin
        dv_valid[j] <= 1'b0;
      end
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s0_valid    <= pos_in.valid;
      s1_valid    <= s0_valid;
      s2_valid    <= s1_valid;
      s3_valid    <= s2_valid;
      dv_valid[0] <= s3_valid;
      for (int j = 0; j < NST; j++) begin
        dv_valid[j+1] <= dv_valid[j];
      end
      m_valid   <= dv_valid[NST];
      out_valid <= m_valid;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_p[0] <= pos_in.pos_x;
      s0_p[1] <= pos_in.pos_y;
      s0_p[2] <= pos_in.pos_z;
      for (int k = 0; k < 3; k++) begin
        // stage 1
        s1_p[k] <= s0_p[k];
        s1_a[k] <= XW'(s0_p[k]) - XW'($signed(falloff_point[LW*k +: LW]));
        s1_d[k] <= XW'(s0_p[k]) - XW'($signed(ref_point[LW*k +: LW]));
        // stage 2
        s2_p[k]  <= s1_p[k];
        s2_d[k]  <= s1_d[k];
        s2_dp[k] <= PW'(s1_a[k]) * PW'($signed(falloff_dir[LW*k +: LW]));
        s2_sp[k] <= PW'(s1_d[k]) * PW'($signed(scale_xyz[LW*k +: LW]));
        // stage 3
        s3_p[k]    <= s2_p[k];
        s3_diff[k] <= FW'($signed(ds_sum[k][SW-1:12])) - FW'(s2_d[k]);
        // classify stage
        dv_p[0][k]    <= s3_p[k];
        dv_diff[0][k] <= s3_diff[k];
      end
      s3_dot <= DW'(s2_dp[0]) + DW'(s2_dp[1]) + DW'(s2_dp[2]);
      dv_rem[0]  <= num;
      dv_quo[0]  <= '0;
      dv_wsel[0] <= wsel_c;
      // division stages
      for (int j = 0; j < NST; j++) begin
        dv_rem[j+1]  <= rem_next[j];
        dv_quo[j+1]  <= quo_next[j];
        dv_wsel[j+1] <= dv_wsel[j];
        for (int k = 0; k < 3; k++) begin
          dv_p[j+1][k]    <= dv_p[j][k];
          dv_diff[j+1][k] <= dv_diff[j][k];
        end
      end
      // weight multiply and output
      m_changed <= (wgt != '0);
      o_changed <= m_changed;
      for (int k = 0; k < 3; k++) begin
        m_p[k]    <= dv_p[NST][k];
        m_prod[k] <= MW'(dv_diff[NST][k]) * MW'($signed({1'b0, wgt}));
        o_c[k]    <= m_changed ? sat[k] : m_p[k];
      end
    end
  end

  assign pos_out.valid       = out_valid;
  assign pos_out.out_x       = o_c[0];
  assign pos_out.out_y       = o_c[1];
  assign pos_out.out_z       = o_c[2];
  assign pos_out.was_changed = o_changed;

endmodule

### tb/sv/vertex_scale_with_falloff_tb.sv
// Testbench for vertex_scale_with_falloff: directed table plus random vertices,
// checked against an in-bench fixed-point predictor across several register settings.
// Depends on vsf_pkg, the vsf_if interfaces and the block itself.
module vertex_scale_with_falloff_tb;

  localparam int CW        = 16;
  localparam int LATENCY   = 23;
  localparam int WDOG_MAX  = 2000;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 changed;
  } scaled_t;

  // Directed row: a vertex, and optionally a result read straight off the spec
  typedef struct {
    vertex_t v;
    bit      fixed;
    scaled_t res;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  vsf_cfg_if                     cfg();
  vsf_pos_in_if  #(.COORD_WIDTH(CW)) pos_in();
  vsf_pos_out_if #(.COORD_WIDTH(CW)) pos_out();

  vertex_scale_with_falloff #(.COORD_WIDTH(CW)) DUT (
    .clk(clk), .rst(rst), .cfg(cfg), .pos_in(pos_in), .pos_out(pos_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the block's registers
  logic [47:0] sh_scale, sh_ref, sh_fpoint, sh_fdir;
  logic        sh_fen;
  logic [14:0] sh_fdist;

  scaled_t pending_q[$];
  int      n_fail = 0;
  int      idle_cycles = 0;
  bit      tx_done = 0;

  function automatic longint lane_of(logic [47:0] packed_v, int k);
    logic signed [15:0] l;
    l = packed_v[16*k +: 16];
    return longint'(l);
  endfunction

  // Floor division by 2^n; >>> on longint floors for negatives
  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint falloff_weight(longint p[3]);
    longint dot;
    dot = 0;
    if (!sh_fen) return 65536;
    for (int k = 0; k < 3; k++)
      dot += (p[k] - lane_of(sh_fpoint, k)) * lane_of(sh_fdir, k);
    if (dot <= 0) return 0;
    if (sh_fdist == 0) return 65536;
    if (dot * 4 >= longint'(sh_fdist) * 65536) return 65536;
    return (dot * 4) / longint'(sh_fdist);
  endfunction

  function automatic scaled_t scale_vertex(vertex_t v);
    longint  p[3];
    longint  w, d, ds, r;
    scaled_t o;
    p[0] = v.x; p[1] = v.y; p[2] = v.z;
    w = falloff_weight(p);
    for (int k = 0; k < 3; k++) begin
      r = p[k];
      if (w > 0) begin
        d  = p[k] - lane_of(sh_ref, k);
        ds = floor_shift(d * lane_of(sh_scale, k) + 2048, 12);
        r  = p[k] + floor_shift((ds - d) * w + 32768, 16);
        if (r > 32767)  r = 32767;
        if (r < -32768) r = -32768;
      end
      case (k)
        0: o.x = r[CW-1:0];
        1: o.y = r[CW-1:0];
        default: o.z = r[CW-1:0];
      endcase
    end
    o.changed = (w > 0);
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    n_fail++;
  endtask

  // Initial drive
  initial begin
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    pos_in.valid = 1'b0; pos_in.pos_x = '0; pos_in.pos_y = '0; pos_in.pos_z = '0;
    pos_out.ready = 1'b0;
  end

  // Receiver: random stalls, compare each transfer against the oldest expectation
  initial begin
    int gap;
    scaled_t want;
    @(negedge clk);
    forever begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        pos_out.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pos_out.ready <= 1'b1;
      @(posedge clk);
      while (!(pos_out.valid && !rst)) @(posedge clk);
      if (pending_q.size() == 0) begin
        report_mismatch("result with no expectation waiting", 1, 0);
      end else begin
        want = pending_q.pop_front();
        if (pos_out.out_x !== want.x) report_mismatch("out_x", pos_out.out_x, want.x);
        if (pos_out.out_y !== want.y) report_mismatch("out_y", pos_out.out_y, want.y);
        if (pos_out.out_z !== want.z) report_mismatch("out_z", pos_out.out_z, want.z);
        if (pos_out.was_changed !== want.changed)
          report_mismatch("was_changed", pos_out.was_changed, want.changed);
      end
      @(negedge clk);
    end
  end

  // Watchdog: cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((pos_in.valid && pos_in.ready) || (pos_out.valid && pos_out.ready) ||
        (cfg.valid && cfg.ready) || rst || tx_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("watchdog expired");
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Register write while idle; shadow tracks the masked value
  task automatic write_reg(logic [vsf_pkg::CFG_IDX_W-1:0] idx, logic [47:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      vsf_pkg::REG_SCALE_XYZ:      sh_scale  = val;
      vsf_pkg::REG_REF_POINT:      sh_ref    = val;
      vsf_pkg::REG_FALLOFF_ENABLE: sh_fen    = val[0];
      vsf_pkg::REG_FALLOFF_POINT:  sh_fpoint = val;
      vsf_pkg::REG_FALLOFF_DIR:    sh_fdir   = val;
      vsf_pkg::REG_FULL_DISTANCE:  sh_fdist  = val[14:0];
      default: ;
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_vertex(vertex_t v, bit fixed, scaled_t fixed_res);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      pos_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pos_in.valid <= 1'b1;
    pos_in.pos_x <= v.x;
    pos_in.pos_y <= v.y;
    pos_in.pos_z <= v.z;
    @(posedge clk);
    while (!pos_in.ready) @(posedge clk);
    pending_q.push_back(fixed ? fixed_res : scale_vertex(v));
    @(negedge clk);
  endtask

  task automatic drain();
    pos_in.valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic vertex_t rand_vertex();
    vertex_t v;
    v.x = rand_coord(); v.y = rand_coord(); v.z = rand_coord();
    return v;
  endfunction

  function automatic logic [47:0] rand_scale();
    logic [15:0] l[3];
    for (int k = 0; k < 3; k++)
      case ($urandom_range(0, 3))
        0: l[k] = 16'($urandom);
        default: l[k] = 16'($urandom_range(0, 16384)) - 16'd8192;
      endcase
    return {l[2], l[1], l[0]};
  endfunction

  // Random phase with a fresh configuration
  task automatic random_phase(int count);
    scaled_t none;
    none = '0;
    write_reg(vsf_pkg::REG_SCALE_XYZ, rand_scale());
    write_reg(vsf_pkg::REG_REF_POINT, 48'({$urandom, $urandom}));
    write_reg(vsf_pkg::REG_FALLOFF_ENABLE, 48'($urandom_range(0, 3) != 0));
    write_reg(vsf_pkg::REG_FALLOFF_POINT,
              {16'($urandom), 16'($urandom), 16'($urandom)});
    write_reg(vsf_pkg::REG_FALLOFF_DIR, {16'($urandom), 16'($urandom), 16'($urandom)});
    write_reg(vsf_pkg::REG_FULL_DISTANCE,
              $urandom_range(0, 3) == 0 ? 48'd0 : 48'($urandom_range(1, 32767)));
    for (int i = 0; i < count; i++) send_vertex(rand_vertex(), 1'b0, none);
    drain();
  endtask

  // Stimulus
  initial begin
    vec_row_t rows[$];
    vec_row_t row;
    sh_scale = vsf_pkg::SCALE_RESET; sh_ref = '0; sh_fen = 1'b0;
    sh_fpoint = '0; sh_fdir = '0; sh_fdist = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // After reset: unit scale keeps every vertex, still flagged as changed
    row.fixed = 1; row.v = '{16'sh7FFF, 16'sh8000, 16'sh0000};
    row.res = '{16'sh7FFF, 16'sh8000, 16'sh0000, 1'b1}; rows.push_back(row);
    row.v = '{16'sh0100, -16'sh0100, 16'sh1234};
    row.res = '{16'sh0100, -16'sh0100, 16'sh1234, 1'b1}; rows.push_back(row);
    foreach (rows[i]) send_vertex(rows[i].v, 1'b1, rows[i].res);
    drain();

    // Extremes: max scale with a reference offset, then most negative scale without one; large vertices saturate
    write_reg(vsf_pkg::REG_SCALE_XYZ, 48'h7FFF_7FFF_7FFF);
    write_reg(vsf_pkg::REG_REF_POINT, 48'h8000_7FFF_0100);
    rows.delete();
    row.fixed = 0;
    row.v = '{16'sh7FFF, 16'sh8000, 16'sh0001}; rows.push_back(row);
    row.v = '{16'sh8000, 16'sh7FFF, 16'shFFFF}; rows.push_back(row);
    row.v = '{16'sh0000, 16'sh0000, 16'sh0000}; rows.push_back(row);
    foreach (rows[i]) send_vertex(rows[i].v, 1'b0, rows[i].res);
    drain();
    write_reg(vsf_pkg::REG_SCALE_XYZ, 48'h8000_8000_8000);
    write_reg(vsf_pkg::REG_REF_POINT, 48'h0);
    foreach (rows[i]) send_vertex(rows[i].v, 1'b0, rows[i].res);
    drain();

    // Falloff with step: direction +x, falloff point at origin
    write_reg(vsf_pkg::REG_SCALE_XYZ, 48'h2000_2000_2000);
    write_reg(vsf_pkg::REG_FALLOFF_ENABLE, 48'd1);
    write_reg(vsf_pkg::REG_FALLOFF_DIR, 48'h0000_0000_4000);
    write_reg(vsf_pkg::REG_FULL_DISTANCE, 48'd0);
    rows.delete();
    // Negative or zero dot product: vertex passes unchanged
    row.fixed = 1; row.v = '{-16'sh0100, 16'sh0500, 16'sh0600};
    row.res = '{-16'sh0100, 16'sh0500, 16'sh0600, 1'b0}; rows.push_back(row);
    row.v = '{16'sh0000, 16'sh7FFF, 16'sh8000};
    row.res = '{16'sh0000, 16'sh7FFF, 16'sh8000, 1'b0}; rows.push_back(row);
    row.fixed = 0; row.v = '{16'sh0001, 16'sh0100, 16'sh0200}; rows.push_back(row);
    row.v = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}; rows.push_back(row);
    foreach (rows[i]) send_vertex(rows[i].v, 1'b1 & rows[i].fixed, rows[i].res);
    drain();

    // Linear falloff; tiny dot truncating to zero weight, and maximum distance
    write_reg(vsf_pkg::REG_FULL_DISTANCE, 48'h7FFF);
    write_reg(vsf_pkg::REG_FALLOFF_DIR, 48'h0000_0000_0001);
    rows.delete();
    row.fixed = 1; row.v = '{16'sh0001, 16'sh0010, 16'sh0020};
    row.res = '{16'sh0001, 16'sh0010, 16'sh0020, 1'b0}; rows.push_back(row);
    row.fixed = 0; row.v = '{16'sh7FFF, 16'sh0010, 16'sh0020}; rows.push_back(row);
    foreach (rows[i]) send_vertex(rows[i].v, rows[i].fixed, rows[i].res);
    drain();
    write_reg(vsf_pkg::REG_FALLOFF_DIR, 48'h8000_7FFF_C000);
    write_reg(vsf_pkg::REG_FALLOFF_POINT, 48'h7FFF_8000_0100);
    write_reg(vsf_pkg::REG_FULL_DISTANCE, 48'd1);
    rows.delete();
    row.fixed = 0;
    row.v = '{16'sh0100, 16'sh0200, 16'sh8000}; rows.push_back(row);
    row.v = '{16'sh8000, 16'sh7FFF, 16'sh0000}; rows.push_back(row);
    foreach (rows[i]) send_vertex(rows[i].v, 1'b0, rows[i].res);
    drain();
    // Index beyond the list is ignored
    write_reg(3'd6, 48'hFFFF_FFFF_FFFF);
    write_reg(3'd7, 48'hFFFF_FFFF_FFFF);
    send_vertex('{16'sh0123, 16'sh0456, 16'sh0789}, 1'b0, '0);
    drain();

    // Random phases, each drained before reconfiguring
    for (int ph = 0; ph < 12; ph++) random_phase(50);

    tx_done = 1;
    if (n_fail == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
